FILE: sv/qsrm_pkg.sv
// Shared types and constants for the quote spread rolling mean block.
// Used by qsrm_ctrl, qsrm_datapath and quote_spread_rolling_mean_top; depends on nothing.
package qsrm_pkg;

    localparam int CFG_W               = 9;
    localparam int CBPS_W              = 22;
    localparam int CENTIBPS_SCALE_BITS = 21;
    localparam logic [CENTIBPS_SCALE_BITS-1:0] CENTIBPS_SCALE = 21'd2000000;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVICT,
        ST_ACCUM,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic evict;
        logic accum;
        logic setup;
        logic step;
        logic cbps_step;
        logic finish;
    } cmd_t;

endpackage

FILE: sv/quote_spread_rolling_mean_top.sv
// Quote spread rolling mean: top level joining the sequencer and the datapath.
// Depends on qsrm_pkg, qsrm_ctrl and qsrm_datapath.
//
// Usage
//   Input channel: in_valid / in_stall with bid_price and ask_price. A request
//   is taken at a clock edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with spread, mid_doubled,
//   spread_centibps, rolling_mean and window_fill, one result per request.
//   Configuration: cfg_write_en / cfg_write_data sets the window length and
//   empties the window; write only while no request is in flight.
//   The result comes from the bit-serial mean divider, which runs one
//   quotient bit per cycle over the SUM_W-bit window sum; the centibps
//   divider runs alongside it over the 21 scale bits. A new request is
//   taken only once the previous one has reached its finish state.
//   A finished result waits in the output register while out_stall is high;
//   the next request is taken meanwhile and its result holds in the datapath
//   until the output register frees up.
//   Reset clears the window and sets the window length to 100; no clearing
//   pass is needed.
module quote_spread_rolling_mean_top #(
    parameter int PRICE_BITS = 48,
    parameter int MAX_WINDOW = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [qsrm_pkg::CFG_W-1:0]         cfg_write_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [PRICE_BITS-1:0]              bid_price,
    input  logic [PRICE_BITS-1:0]              ask_price,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [PRICE_BITS:0]         spread,
    output logic [PRICE_BITS:0]                mid_doubled,
    output logic signed [qsrm_pkg::CBPS_W-1:0] spread_centibps,
    output logic signed [PRICE_BITS:0]         rolling_mean,
    output logic [$clog2(MAX_WINDOW + 1)-1:0]  window_fill
);
    import qsrm_pkg::*;

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = PRICE_BITS + 1 + ADDR_W;

    cmd_t cmd;

    qsrm_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    qsrm_datapath #(
        .PRICE_BITS (PRICE_BITS),
        .MAX_WINDOW (MAX_WINDOW),
        .FILL_W     (FILL_W),
        .SUM_W      (SUM_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .bid_price       (bid_price),
        .ask_price       (ask_price),
        .spread          (spread),
        .mid_doubled     (mid_doubled),
        .spread_centibps (spread_centibps),
        .rolling_mean    (rolling_mean),
        .window_fill     (window_fill)
    );

endmodule

FILE: sv/qsrm_ctrl.sv
// Sequencer for the quote spread rolling mean block: state machine, divide counter, output valid.
// Depends on qsrm_pkg; drives qsrm_datapath through a cmd_t bundle.
module qsrm_ctrl #(
    parameter int SUM_W = 57
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output qsrm_pkg::cmd_t cmd
);
    import qsrm_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;
    logic             last_step;

    assign slot_free = !out_valid_reg || !out_stall;
    assign last_step = (cnt_reg == CNT_W'(SUM_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_EVICT;
            ST_EVICT:  state_next = ST_ACCUM;
            ST_ACCUM:  state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE: if (last_step) state_next = ST_FINISH;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_FETCH:  cmd.fetch = 1'b1;
            ST_EVICT:  cmd.evict = 1'b1;
            ST_ACCUM:  cmd.accum = 1'b1;
            ST_SETUP:  cmd.setup = 1'b1;
            ST_DIVIDE:
            begin
                cmd.step      = 1'b1;
                cmd.cbps_step = (32'(cnt_reg) < CENTIBPS_SCALE_BITS);
            end
            ST_FINISH: cmd.finish = slot_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_SETUP)
            cnt_next = '0;
        else if (state_reg == ST_DIVIDE)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/qsrm_datapath.sv
// Datapath for the quote spread rolling mean block: spread ring, window sum,
// radix-2 centibps divider, restoring mean divider and output registers.
// Depends on qsrm_pkg; sequenced by qsrm_ctrl through a cmd_t bundle.
module qsrm_datapath #(
    parameter int PRICE_BITS = 48,
    parameter int MAX_WINDOW = 256,
    parameter int FILL_W     = 9,
    parameter int SUM_W      = 57
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qsrm_pkg::cmd_t                cmd,
    input  logic                          cfg_write_en,
    input  logic [qsrm_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic [PRICE_BITS-1:0]         bid_price,
    input  logic [PRICE_BITS-1:0]         ask_price,
    output logic signed [PRICE_BITS:0]    spread,
    output logic [PRICE_BITS:0]           mid_doubled,
    output logic signed [qsrm_pkg::CBPS_W-1:0] spread_centibps,
    output logic signed [PRICE_BITS:0]    rolling_mean,
    output logic [FILL_W-1:0]             window_fill
);
    import qsrm_pkg::*;

    localparam int SPREAD_W = PRICE_BITS + 1;
    localparam int ADDR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int REM_W    = FILL_W + 1;
    localparam int T_W      = SPREAD_W + 2;

    logic [SPREAD_W-1:0]     ring_mem [MAX_WINDOW];

    logic [PRICE_BITS-1:0]   bid_reg;
    logic [PRICE_BITS-1:0]   ask_reg;
    logic [CFG_W-1:0]        window_length_reg;
    logic [SPREAD_W-1:0]     spread_reg;
    logic [SPREAD_W-1:0]     mid_reg;
    logic [PRICE_BITS-1:0]   mag_reg;
    logic                    neg_reg;
    logic [SPREAD_W-1:0]     rd_data_reg;
    logic                    evict_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [ADDR_W-1:0]       write_index_reg;
    logic                    sum_neg_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [SPREAD_W-1:0]     cb_r_reg;
    logic [CBPS_W-1:0]       cb_q_reg;
    logic [CENTIBPS_SCALE_BITS-1:0] scale_sh_reg;

    logic [SPREAD_W-1:0]     spread_out_reg;
    logic [SPREAD_W-1:0]     mid_out_reg;
    logic [CBPS_W-1:0]       cbps_out_reg;
    logic [SPREAD_W-1:0]     mean_out_reg;
    logic [FILL_W-1:0]       fill_out_reg;

    logic [FILL_W-1:0]       win;
    logic [FILL_W:0]         wi_ext;
    logic [FILL_W:0]         oldest_ext;
    logic [ADDR_W-1:0]       oldest;
    logic [REM_W-1:0]        rem_shift;
    logic [REM_W:0]          rem_diff;
    logic [T_W-1:0]          cb_t;
    logic [T_W:0]            cb_d1;
    logic [T_W:0]            cb_d2;
    logic [1:0]              cb_digit;
    logic [SPREAD_W-1:0]     cb_r_next;
    logic [SPREAD_W-1:0]     mean_mag;

    always_comb
    begin
        if (window_length_reg == '0)
            win = FILL_W'(1);
        else if (32'(window_length_reg) > MAX_WINDOW)
            win = FILL_W'(MAX_WINDOW);
        else
            win = FILL_W'(window_length_reg);
    end

    always_comb
    begin
        wi_ext = (FILL_W + 1)'(write_index_reg);
        if (wi_ext >= {1'b0, fill_reg})
            oldest_ext = wi_ext - {1'b0, fill_reg};
        else
            oldest_ext = wi_ext + (FILL_W + 1)'(MAX_WINDOW) - {1'b0, fill_reg};
        oldest = oldest_ext[ADDR_W-1:0];
    end

    // mean divider: one quotient bit per step
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
        rem_diff  = {1'b0, rem_shift} - (REM_W + 1)'(fill_reg);
    end

    // centibps divider: one scale bit per step, quotient digit 0..2
    always_comb
    begin
        cb_t  = {1'b0, cb_r_reg, 1'b0}
              + (scale_sh_reg[CENTIBPS_SCALE_BITS-1] ? T_W'(mag_reg) : T_W'(0));
        cb_d1 = {1'b0, cb_t} - (T_W + 1)'(mid_reg);
        cb_d2 = {1'b0, cb_t} - {2'b00, mid_reg, 1'b0};
        if (!cb_d2[T_W])
        begin
            cb_digit  = 2'd2;
            cb_r_next = cb_d2[SPREAD_W-1:0];
        end
        else if (!cb_d1[T_W])
        begin
            cb_digit  = 2'd1;
            cb_r_next = cb_d1[SPREAD_W-1:0];
        end
        else
        begin
            cb_digit  = 2'd0;
            cb_r_next = cb_t[SPREAD_W-1:0];
        end
    end

    assign mean_mag = quo_reg[SPREAD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
            rd_data_reg <= ring_mem[oldest];
        if (cmd.evict)
            ring_mem[write_index_reg] <= spread_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            sum_reg           <= '0;
            fill_reg          <= '0;
            write_index_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            window_length_reg <= cfg_write_data;
            sum_reg           <= '0;
            fill_reg          <= '0;
            write_index_reg   <= '0;
        end
        else
        begin
            if (cmd.evict)
            begin
                if (evict_reg)
                begin
                    sum_reg  <= sum_reg - {{ADDR_W{rd_data_reg[SPREAD_W-1]}}, rd_data_reg};
                    fill_reg <= win;
                end
                else
                    fill_reg <= fill_reg + FILL_W'(1);
                if (write_index_reg == ADDR_W'(MAX_WINDOW - 1))
                    write_index_reg <= '0;
                else
                    write_index_reg <= write_index_reg + ADDR_W'(1);
            end
            if (cmd.accum)
                sum_reg <= sum_reg + {{ADDR_W{spread_reg[SPREAD_W-1]}}, spread_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bid_reg <= bid_price;
            ask_reg <= ask_price;
        end
        if (cmd.fetch)
        begin
            spread_reg <= {1'b0, ask_reg} - {1'b0, bid_reg};
            mid_reg    <= {1'b0, ask_reg} + {1'b0, bid_reg};
            neg_reg    <= ask_reg < bid_reg;
            mag_reg    <= (ask_reg < bid_reg) ? bid_reg - ask_reg : ask_reg - bid_reg;
            evict_reg  <= fill_reg >= win;
        end
        if (cmd.setup)
        begin
            sum_neg_reg  <= sum_reg[SUM_W-1];
            quo_reg      <= sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
            rem_reg      <= '0;
            cb_r_reg     <= '0;
            cb_q_reg     <= '0;
            scale_sh_reg <= CENTIBPS_SCALE;
        end
        if (cmd.step)
        begin
            if (!rem_diff[REM_W])
            begin
                rem_reg <= rem_diff[REM_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.cbps_step)
        begin
            cb_r_reg     <= cb_r_next;
            cb_q_reg     <= {cb_q_reg[CBPS_W-2:0], 1'b0} + CBPS_W'(cb_digit);
            scale_sh_reg <= {scale_sh_reg[CENTIBPS_SCALE_BITS-2:0], 1'b0};
        end
        if (cmd.finish)
        begin
            spread_out_reg <= spread_reg;
            mid_out_reg    <= mid_reg;
            if (mid_reg == '0)
                cbps_out_reg <= '0;
            else
                cbps_out_reg <= neg_reg ? -cb_q_reg : cb_q_reg;
            mean_out_reg   <= sum_neg_reg ? -mean_mag : mean_mag;
            fill_out_reg   <= fill_reg;
        end
    end

    assign spread          = spread_out_reg;
    assign mid_doubled     = mid_out_reg;
    assign spread_centibps = cbps_out_reg;
    assign rolling_mean    = mean_out_reg;
    assign window_fill     = fill_out_reg;

endmodule

FILE: tb/quote_spread_rolling_mean_checker.sv
// Checker for the quote spread rolling mean block: watches the config write, both channels,
// predicts each result from its own window model and compares them in order.
// Depends on qsrm_pkg for the scale constant, the config width and the window reset value.
`timescale 1ns / 1ps
module quote_spread_rolling_mean_checker #(
    parameter int PRICE_BITS = 48,
    parameter int MAX_WINDOW = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [qsrm_pkg::CFG_W-1:0]         cfg_write_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [PRICE_BITS-1:0]              bid_price,
    input  logic [PRICE_BITS-1:0]              ask_price,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [PRICE_BITS:0]         spread,
    input  logic [PRICE_BITS:0]                mid_doubled,
    input  logic signed [qsrm_pkg::CBPS_W-1:0] spread_centibps,
    input  logic signed [PRICE_BITS:0]         rolling_mean,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]  window_fill,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked_count
);
    import qsrm_pkg::*;

    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int FIFO_DEPTH = 16;

    typedef struct {
        logic signed [PRICE_BITS:0] spread;
        logic [PRICE_BITS:0]        mid;
        logic signed [CBPS_W-1:0]   cbps;
        logic signed [PRICE_BITS:0] mean;
        logic [FILL_W-1:0]          fill;
    } quote_stats_t;

    quote_stats_t               stats_fifo[FIFO_DEPTH];
    int                         fifo_rd;
    int                         fifo_wr;
    int                         fifo_count;
    logic signed [PRICE_BITS:0] spread_hist[MAX_WINDOW];
    longint                     hist_sum;
    int                         hist_fill;
    int                         hist_head;
    int                         window_len;

    function automatic int clamp_window(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(w);
    endfunction

    function automatic quote_stats_t quote_stats(input logic [PRICE_BITS-1:0] bid,
                                                 input logic [PRICE_BITS-1:0] ask);
        quote_stats_t               res;
        logic [PRICE_BITS-1:0]      mag;
        logic [127:0]               num;
        logic [127:0]               den;
        logic [127:0]               quo;
        logic                       neg;
        int                         oldest;
        longint                     m;
        neg        = ask < bid;
        mag        = neg ? bid - ask : ask - bid;
        res.spread = $signed({1'b0, ask} - {1'b0, bid});
        res.mid    = {1'b0, ask} + {1'b0, bid};
        res.cbps   = '0;
        if (res.mid != 0)
        begin
            num = 128'(mag);
            num = num * 128'(CENTIBPS_SCALE);
            den = 128'(res.mid);
            quo = num / den;
            res.cbps = neg ? CBPS_W'(128'd0 - quo) : CBPS_W'(quo);
        end
        if (hist_fill >= window_len)
        begin
            oldest    = (hist_head + MAX_WINDOW - hist_fill) % MAX_WINDOW;
            hist_sum  = hist_sum - longint'(spread_hist[oldest]);
            hist_fill = window_len;
        end
        else
            hist_fill = hist_fill + 1;
        spread_hist[hist_head] = res.spread;
        hist_sum  = hist_sum + longint'(res.spread);
        hist_head = (hist_head + 1) % MAX_WINDOW;
        m         = hist_sum / longint'(hist_fill);
        res.mean  = m[PRICE_BITS:0];
        res.fill  = FILL_W'(hist_fill);
        return res;
    endfunction

    task automatic report_field(input string name, input logic [127:0] want,
                                input logic [127:0] got);
        if (fail_count < 10)
            $display("  %s: expected %0h, got %0h (result %0d)", name, want, got,
                     checked_count);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        quote_stats_t want;
        quote_stats_t pred;
        if (!rst_n)
        begin
            fifo_rd       = 0;
            fifo_wr       = 0;
            fifo_count    = 0;
            fail_count    = 0;
            checked_count = 0;
            hist_sum      = 0;
            hist_fill     = 0;
            hist_head     = 0;
            window_len    = clamp_window(WINDOW_RESET);
        end
        else
        begin
            if (cfg_write_en)
            begin
                window_len = clamp_window(cfg_write_data);
                hist_sum   = 0;
                hist_fill  = 0;
                hist_head  = 0;
            end
            if (in_valid && !in_stall)
            begin
                pred = quote_stats(bid_price, ask_price);
                if (fifo_count == FIFO_DEPTH)
                begin
                    if (fail_count < 10)
                        $display("  too many requests outstanding");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    stats_fifo[fifo_wr] = pred;
                    fifo_wr    = (fifo_wr + 1) % FIFO_DEPTH;
                    fifo_count = fifo_count + 1;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (fifo_count == 0)
                begin
                    if (fail_count < 10)
                        $display("  result with no request outstanding");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want       = stats_fifo[fifo_rd];
                    fifo_rd    = (fifo_rd + 1) % FIFO_DEPTH;
                    fifo_count = fifo_count - 1;
                    if (spread !== want.spread)
                        report_field("spread", 128'($unsigned(want.spread)),
                                     128'($unsigned(spread)));
                    if (mid_doubled !== want.mid)
                        report_field("mid_doubled", 128'(want.mid), 128'(mid_doubled));
                    if (spread_centibps !== want.cbps)
                        report_field("spread_centibps", 128'($unsigned(want.cbps)),
                                     128'($unsigned(spread_centibps)));
                    if (rolling_mean !== want.mean)
                        report_field("rolling_mean", 128'($unsigned(want.mean)),
                                     128'($unsigned(rolling_mean)));
                    if (window_fill !== want.fill)
                        report_field("window_fill", 128'(want.fill), 128'(window_fill));
                end
                checked_count = checked_count + 1;
            end
        end
        pending = fifo_count;
    end

endmodule

FILE: tb/quote_spread_rolling_mean_top_test.sv
// Testbench top for quote_spread_rolling_mean_top: drives quotes and window settings with
// random idling on both channels and gives the verdict.
// Depends on qsrm_pkg, the block itself and quote_spread_rolling_mean_checker.
`timescale 1ns / 1ps
module quote_spread_rolling_mean_top_test;
    import qsrm_pkg::*;

    localparam int PRICE_BITS   = 48;
    localparam int MAX_WINDOW   = 256;
    localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES       = 10;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

    logic                        clk            = 1'b0;
    logic                        rst_n          = 1'b0;
    logic                        cfg_write_en   = 1'b0;
    logic [CFG_W-1:0]            cfg_write_data = '0;
    logic                        in_valid       = 1'b0;
    logic                        in_stall;
    logic [PRICE_BITS-1:0]       bid_price      = '0;
    logic [PRICE_BITS-1:0]       ask_price      = '0;
    logic                        out_valid;
    logic                        out_stall      = 1'b0;
    logic signed [PRICE_BITS:0]  spread;
    logic [PRICE_BITS:0]         mid_doubled;
    logic signed [CBPS_W-1:0]    spread_centibps;
    logic signed [PRICE_BITS:0]  rolling_mean;
    logic [FILL_W-1:0]           window_fill;
    logic                        gaps_on        = 1'b1;
    int                          fail_count;
    int                          pending;
    int                          checked_count;
    int                          cycle_count    = 0;
    int                          quotes_sent    = 0;
    int                          window_writes  = 0;

    quote_spread_rolling_mean_top #(
        .PRICE_BITS(PRICE_BITS),
        .MAX_WINDOW(MAX_WINDOW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .bid_price(bid_price),
        .ask_price(ask_price),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .spread(spread),
        .mid_doubled(mid_doubled),
        .spread_centibps(spread_centibps),
        .rolling_mean(rolling_mean),
        .window_fill(window_fill)
    );

    quote_spread_rolling_mean_checker #(
        .PRICE_BITS(PRICE_BITS),
        .MAX_WINDOW(MAX_WINDOW)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .bid_price(bid_price),
        .ask_price(ask_price),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .spread(spread),
        .mid_doubled(mid_doubled),
        .spread_centibps(spread_centibps),
        .rolling_mean(rolling_mean),
        .window_fill(window_fill),
        .fail_count(fail_count),
        .pending(pending),
        .checked_count(checked_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("quote_spread_rolling_mean_top: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= gaps_on && ($urandom_range(99) < 18);

    task automatic send_quote(input logic [PRICE_BITS-1:0] bid,
                              input logic [PRICE_BITS-1:0] ask);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        bid_price <= bid;
        ask_price <= ask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quotes_sent = quotes_sent + 1;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] len);
        drain_results();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        window_writes = window_writes + 1;
    endtask

    function automatic void make_quote(output logic [PRICE_BITS-1:0] bid,
                                       output logic [PRICE_BITS-1:0] ask);
        logic [63:0]           r1;
        logic [63:0]           r2;
        logic [PRICE_BITS-1:0] d;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        case ($urandom_range(9))
            0:
            begin
                bid = r1[PRICE_BITS-1:0];
                ask = r2[PRICE_BITS-1:0];
            end
            1:
            begin
                bid = PRICE_BITS'($urandom_range(15));
                ask = PRICE_BITS'($urandom_range(15));
            end
            2:
            begin
                ask = PRICE_MAX - PRICE_BITS'($urandom_range(3));
                bid = ask - PRICE_BITS'($urandom_range(1000));
            end
            3:
            begin
                bid = r1[PRICE_BITS-1:0] >> $urandom_range(PRICE_BITS - 1);
                d   = PRICE_BITS'($urandom_range(50));
                ask = (bid > d) ? bid - d : '0;
            end
            default:
            begin
                bid = r1[PRICE_BITS-1:0] >> $urandom_range(40);
                ask = bid + PRICE_BITS'($urandom_range(2000));
            end
        endcase
    endfunction

    initial
    begin
        int                    phase_len[PHASES];
        logic [CFG_W-1:0]      phase_win[PHASES];
        logic [PRICE_BITS-1:0] b;
        logic [PRICE_BITS-1:0] a;
        phase_win = '{9'd1, 9'd3, 9'd256, 9'd256, 9'd257, 9'd37, 9'd100, 9'd255, 9'd0,
                      CFG_W'($urandom_range(511))};
        phase_len = '{40, 80, 300, 20, 280, 120, 150, 200, 30, 80};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_quote('0, '0);
        send_quote(PRICE_MAX, PRICE_MAX);
        send_quote('0, PRICE_MAX);
        send_quote(PRICE_MAX, '0);
        send_quote(48'd1, 48'd0);
        send_quote(48'd0, 48'd1);
        send_quote(PRICE_MAX, PRICE_MAX - PRICE_BITS'(1));
        send_quote(PRICE_MAX - PRICE_BITS'(1), PRICE_MAX);
        send_quote(48'd100, 48'd101);
        send_quote(48'd101, 48'd100);
        set_window(9'd0);
        send_quote(48'd3, 48'd5);
        send_quote(48'd5, 48'd3);
        set_window(9'd511);
        send_quote(PRICE_MAX, '0);
        send_quote('0, PRICE_MAX);
        set_window(9'd2);
        send_quote(48'd10, 48'd20);
        send_quote(48'd30, 48'd10);
        send_quote(48'd7, 48'd7);
        send_quote(48'd1, 48'd1000);

        for (int p = 0; p < PHASES; p++)
        begin
            set_window(phase_win[p]);
            gaps_on = (p != 4);
            for (int i = 0; i < phase_len[p]; i++)
            begin
                if (p == 2 && i == 150)
                    drain_results();
                make_quote(b, a);
                send_quote(b, a);
            end
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("sent %0d quotes across %0d window settings (1, 2, 256, saturated, zero),",
                 quotes_sent, window_writes);
        $display("checked %0d results including window wrap and crossed quotes", checked_count);
        if (fail_count == 0 && pending == 0)
            $display("quote_spread_rolling_mean_top: match");
        else
            $display("quote_spread_rolling_mean_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
sv/qsrm_pkg.sv
sv/qsrm_ctrl.sv
sv/qsrm_datapath.sv
sv/quote_spread_rolling_mean_top.sv
tb/quote_spread_rolling_mean_checker.sv
tb/quote_spread_rolling_mean_top_test.sv
